/* design/pvc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pvc_pkg;

   // Field and datapath widths.
   localparam int DATA_W     = 32;   // Q16.16 velocities, gains and force
   localparam int ERR_W      = 33;   // error, Q17.16
   localparam int DT_W       = 31;   // step time, unsigned Q15.16
   localparam int STAMP_W    = 32;
   localparam int WIN_W      = 16;
   localparam int INTEG_W    = 48;   // integral, Q32.16
   localparam int DE_W       = 34;   // error change
   localparam int NUM_W      = 49;   // |error change| shifted up by 16
   localparam int DER_W      = 50;   // derivative
   localparam int SQ_W       = 47;   // ref * |ref|, Q31.16
   localparam int MUL_W      = 33;   // shared multiplier operand
   localparam int PROD_W     = 66;
   localparam int ACC_W      = 88;   // output sum, Q56.32
   localparam int REM_W      = 31;
   localparam int DIV_CNT_W  = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDFWD_GAIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_WINDOW = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [DATA_W-1:0] FEEDFWD_GAIN_RST  = 32'd8898332;
   localparam logic [WIN_W-1:0]  SETTLE_WINDOW_RST = 16'd150;

   // Operation codes of an input word.
   localparam logic OP_STEP  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INC_MUL,
      ST_INC,
      ST_SQ,
      ST_KI_LO,
      ST_KI_HI,
      ST_FF_LO,
      ST_FF_HI,
      ST_FF_ACC,
      ST_DIV_WAIT,
      ST_DERIV,
      ST_KD_LO,
      ST_KD_HI,
      ST_LAST,
      ST_OUT
   } state_type;

   // Operand pair presented to the shared multiplier.
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_E_DT,
      MUL_REF_SQ,
      MUL_KP_E,
      MUL_KI_ILO,
      MUL_KI_IHI,
      MUL_FF_QLO,
      MUL_FF_QHI,
      MUL_KD_DLO,
      MUL_KD_DHI
   } mul_sel_type;

   // Use of the product registered in the previous cycle.
   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_INC,
      ACC_SQ,
      ACC_FIRST,
      ACC_ADD_LO,
      ACC_ADD_HI
   } acc_op_type;

   typedef struct packed {
      logic        capture;
      logic        start;
      logic        prep;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        deriv_load;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } status_type;

endpackage

`default_nettype wire

/* design/pvc_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one control word per handshake.
interface pvc_req_if;
   logic                              valid;
   logic                              ready;
   logic                              operation;
   logic signed [pvc_pkg::DATA_W-1:0] velocity_meas;
   logic signed [pvc_pkg::DATA_W-1:0] velocity_ref;
   logic [pvc_pkg::STAMP_W-1:0]       ref_stamp;
   logic [pvc_pkg::STAMP_W-1:0]       now_stamp;
   logic [pvc_pkg::DT_W-1:0]          step_time;

   modport source (
      output valid, operation, velocity_meas, velocity_ref, ref_stamp, now_stamp,
             step_time,
      input  ready
   );
   modport sink (
      input  valid, operation, velocity_meas, velocity_ref, ref_stamp, now_stamp,
             step_time,
      output ready
   );
endinterface

// Response channel: one force word per handshake.
interface pvc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [pvc_pkg::DATA_W-1:0] drive_force;
   logic                              clipped;

   modport source (
      output valid, drive_force, clipped,
      input  ready
   );
   modport sink (
      input  valid, drive_force, clipped,
      output ready
   );
endinterface

`default_nettype wire

/* design/pvc_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module pvc_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [pvc_pkg::NUM_W-1:0]     dividend,
   input  wire logic [pvc_pkg::DT_W-1:0]      divisor,
   output logic                               busy,
   output logic [pvc_pkg::NUM_W-1:0]          quotient
);
   import pvc_pkg::*;

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [DT_W-1:0]      dvs_ff, dvs_in;

   logic [REM_W:0]       rem_sh;
   logic [REM_W+1:0]     diff;

   // One restoring step per cycle: the dividend shifts out at the top of
   // the quotient register while quotient bits shift in at the bottom.
   always_comb begin
      rem_sh = {rem_ff, quo_ff[NUM_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, dvs_ff};
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (start) begin
         cnt_in = DIV_CNT_W'(NUM_W);
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (!diff[REM_W+1]) begin
            rem_in = diff[REM_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[REM_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* design/pvc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module pvc_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire pvc_pkg::cmd_type                  cmd,
   output pvc_pkg::status_type                    status,
   input  wire logic signed [pvc_pkg::DATA_W-1:0] velocity_meas,
   input  wire logic signed [pvc_pkg::DATA_W-1:0] velocity_ref,
   input  wire logic [pvc_pkg::STAMP_W-1:0]       ref_stamp,
   input  wire logic [pvc_pkg::STAMP_W-1:0]       now_stamp,
   input  wire logic [pvc_pkg::DT_W-1:0]          step_time,
   input  wire logic                              csr_write_enable,
   input  wire logic [pvc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pvc_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output logic signed [pvc_pkg::DATA_W-1:0]      drive_force,
   output logic                                   clipped
);
   import pvc_pkg::*;

   // Configuration registers.
   logic [DATA_W-1:0] kp_ff, kp_in;
   logic [DATA_W-1:0] ki_ff, ki_in;
   logic [DATA_W-1:0] kd_ff, kd_in;
   logic [DATA_W-1:0] kf_ff, kf_in;
   logic [WIN_W-1:0]  win_ff, win_in;

   // Captured word.
   logic [DATA_W-1:0]  ref_ff, ref_in;
   logic [MUL_W-1:0]   abs_ref_ff, abs_ref_in;
   logic [ERR_W-1:0]   e_ff, e_in;
   logic [STAMP_W-1:0] rstamp_ff, rstamp_in;
   logic [STAMP_W-1:0] nstamp_ff, nstamp_in;
   logic [DT_W-1:0]    dt_ff, dt_in;

   // Controller state kept across words.
   logic [INTEG_W-1:0] integ_ff, integ_in;
   logic [ERR_W-1:0]   prev_ff, prev_in;

   // Intermediate results.
   logic [DE_W-1:0]    de_ff, de_in;
   logic               gap_le_ff, gap_le_in;
   logic               dt_zero_ff, dt_zero_in;
   logic [SQ_W-1:0]    q_ff, q_in;
   logic [DER_W-1:0]   deriv_ff, deriv_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [DATA_W-1:0]  force_ff, force_in;
   logic               clip_ff, clip_in;

   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic [ERR_W-1:0]        e_word;
   logic [MUL_W-1:0]        ref_ext;
   logic [STAMP_W-1:0]      gap;
   logic [INTEG_W+1:0]      isum;
   logic [INTEG_W-1:0]      isat;
   logic [DE_W-1:0]         de_neg;
   logic [ACC_W-1:0]        prod_ext;
   logic [DER_W-1:0]        quo_ext;
   logic                    div_start;
   logic [NUM_W-1:0]        div_num;
   logic                    div_busy;
   logic [NUM_W-1:0]        div_quo;
   logic [ACC_W-DATA_W-16:0] acc_top;

   // Register writes from the configuration port.
   always_comb begin
      kp_in  = kp_ff;
      ki_in  = ki_ff;
      kd_in  = kd_ff;
      kf_in  = kf_ff;
      win_in = win_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PROP_GAIN:     kp_in  = csr_write_data;
            CSR_INTEG_GAIN:    ki_in  = csr_write_data;
            CSR_DERIV_GAIN:    kd_in  = csr_write_data;
            CSR_FEEDFWD_GAIN:  kf_in  = csr_write_data;
            CSR_SETTLE_WINDOW: win_in = csr_write_data[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Error and reference magnitude of the incoming word.
   assign e_word  = {velocity_ref[DATA_W-1], velocity_ref}
                    - {velocity_meas[DATA_W-1], velocity_meas};
   assign ref_ext = {velocity_ref[DATA_W-1], velocity_ref};

   always_comb begin
      ref_in     = ref_ff;
      abs_ref_in = abs_ref_ff;
      e_in       = e_ff;
      rstamp_in  = rstamp_ff;
      nstamp_in  = nstamp_ff;
      dt_in      = dt_ff;
      if (cmd.capture) begin
         ref_in     = velocity_ref;
         abs_ref_in = velocity_ref[DATA_W-1] ? (MUL_W'(0) - ref_ext) : ref_ext;
         e_in       = e_word;
         rstamp_in  = ref_stamp;
         nstamp_in  = now_stamp;
         dt_in      = step_time;
      end
   end

   // Error change, settle window test and zero step time flag.
   assign gap = (nstamp_ff >= rstamp_ff) ? (nstamp_ff - rstamp_ff)
                                         : (rstamp_ff - nstamp_ff);

   always_comb begin
      de_in      = de_ff;
      gap_le_in  = gap_le_ff;
      dt_zero_in = dt_zero_ff;
      if (cmd.prep) begin
         de_in      = {e_ff[ERR_W-1], e_ff} - {prev_ff[ERR_W-1], prev_ff};
         gap_le_in  = (gap <= {{(STAMP_W-WIN_W){1'b0}}, win_ff});
         dt_zero_in = (dt_ff == '0);
      end
   end

   // Shared signed multiplier; wide operands go in a low unsigned word and
   // a signed high part.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_E_DT: begin
            mul_a = e_ff;
            mul_b = {{(MUL_W-DT_W){1'b0}}, dt_ff};
         end
         MUL_REF_SQ: begin
            mul_a = {ref_ff[DATA_W-1], ref_ff};
            mul_b = abs_ref_ff;
         end
         MUL_KP_E: begin
            mul_a = {kp_ff[DATA_W-1], kp_ff};
            mul_b = e_ff;
         end
         MUL_KI_ILO: begin
            mul_a = {ki_ff[DATA_W-1], ki_ff};
            mul_b = {1'b0, integ_ff[31:0]};
         end
         MUL_KI_IHI: begin
            mul_a = {ki_ff[DATA_W-1], ki_ff};
            mul_b = {{(MUL_W-INTEG_W+32){integ_ff[INTEG_W-1]}}, integ_ff[INTEG_W-1:32]};
         end
         MUL_FF_QLO: begin
            mul_a = {kf_ff[DATA_W-1], kf_ff};
            mul_b = {1'b0, q_ff[31:0]};
         end
         MUL_FF_QHI: begin
            mul_a = {kf_ff[DATA_W-1], kf_ff};
            mul_b = {{(MUL_W-SQ_W+32){q_ff[SQ_W-1]}}, q_ff[SQ_W-1:32]};
         end
         MUL_KD_DLO: begin
            mul_a = {kd_ff[DATA_W-1], kd_ff};
            mul_b = {1'b0, deriv_ff[31:0]};
         end
         MUL_KD_DHI: begin
            mul_a = {kd_ff[DATA_W-1], kd_ff};
            mul_b = {{(MUL_W-DER_W+32){deriv_ff[DER_W-1]}}, deriv_ff[DER_W-1:32]};
         end
         default: ;
      endcase
      prod_in = mul_a * mul_b;
   end

   // Integral update: add floor(e * dt / 2^16), saturate, then clear inside
   // the settle window.
   always_comb begin
      isum = {{2{integ_ff[INTEG_W-1]}}, integ_ff} + prod_ff[PROD_W-1:16];
      if (isum[INTEG_W+1:INTEG_W-1] == 3'b000 || isum[INTEG_W+1:INTEG_W-1] == 3'b111) begin
         isat = isum[INTEG_W-1:0];
      end else if (isum[INTEG_W+1]) begin
         isat = {1'b1, {(INTEG_W-1){1'b0}}};
      end else begin
         isat = {1'b0, {(INTEG_W-1){1'b1}}};
      end
   end

   assign de_neg    = DE_W'(0) - de_ff;
   assign div_start = (cmd.acc_op == ACC_INC);
   assign div_num   = de_ff[DE_W-1] ? {de_neg[NUM_W-17:0], 16'd0}
                                    : {de_ff[NUM_W-17:0], 16'd0};

   always_comb begin
      integ_in = integ_ff;
      prev_in  = prev_ff;
      if (cmd.start) begin
         integ_in = '0;
         prev_in  = e_word;
      end else if (cmd.acc_op == ACC_INC) begin
         integ_in = gap_le_ff ? '0 : isat;
         prev_in  = e_ff;
      end
   end

   // Feedforward square and output sum.
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      q_in   = q_ff;
      acc_in = acc_ff;
      case (cmd.acc_op)
         ACC_SQ:     q_in   = prod_ff[SQ_W+15:16];
         ACC_FIRST:  acc_in = prod_ext;
         ACC_ADD_LO: acc_in = acc_ff + prod_ext;
         ACC_ADD_HI: acc_in = acc_ff + {prod_ext[ACC_W-33:0], 32'd0};
         default: ;
      endcase
   end

   // Signed derivative from the quotient magnitude; zero step time gives zero.
   assign quo_ext = {1'b0, div_quo};

   always_comb begin
      deriv_in = deriv_ff;
      if (cmd.deriv_load) begin
         if (dt_zero_ff) begin
            deriv_in = '0;
         end else if (de_ff[DE_W-1]) begin
            deriv_in = DER_W'(0) - quo_ext;
         end else begin
            deriv_in = quo_ext;
         end
      end
   end

   // Scale to Q16.16 and saturate into the output register.
   assign acc_top = acc_ff[ACC_W-1:DATA_W+15];

   always_comb begin
      force_in = force_ff;
      clip_in  = clip_ff;
      if (cmd.out_load) begin
         if ((&acc_top) || !(|acc_top)) begin
            force_in = acc_ff[DATA_W+15:16];
            clip_in  = 1'b0;
         end else begin
            force_in = acc_ff[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                       : {1'b0, {(DATA_W-1){1'b1}}};
            clip_in  = 1'b1;
         end
      end
   end

   pvc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (dt_ff),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= '0;
         ki_ff    <= '0;
         kd_ff    <= '0;
         kf_ff    <= FEEDFWD_GAIN_RST;
         win_ff   <= SETTLE_WINDOW_RST;
         integ_ff <= '0;
         prev_ff  <= '0;
      end else begin
         kp_ff    <= kp_in;
         ki_ff    <= ki_in;
         kd_ff    <= kd_in;
         kf_ff    <= kf_in;
         win_ff   <= win_in;
         integ_ff <= integ_in;
         prev_ff  <= prev_in;
      end
      ref_ff     <= ref_in;
      abs_ref_ff <= abs_ref_in;
      e_ff       <= e_in;
      rstamp_ff  <= rstamp_in;
      nstamp_ff  <= nstamp_in;
      dt_ff      <= dt_in;
      de_ff      <= de_in;
      gap_le_ff  <= gap_le_in;
      dt_zero_ff <= dt_zero_in;
      q_ff       <= q_in;
      deriv_ff   <= deriv_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      force_ff   <= force_in;
      clip_ff    <= clip_in;
   end

   assign status.div_busy = div_busy;
   assign drive_force     = force_ff;
   assign clipped         = clip_ff;

endmodule

`default_nettype wire

/* design/pvc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module pvc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_operation,
   output logic                     req_ready,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output pvc_pkg::cmd_type         cmd,
   input  wire pvc_pkg::status_type status
);
   import pvc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_operation == OP_STEP) begin
               state_in = ST_INC_MUL;
            end
         end
         ST_INC_MUL:  state_in = ST_INC;
         ST_INC:      state_in = ST_SQ;
         ST_SQ:       state_in = ST_KI_LO;
         ST_KI_LO:    state_in = ST_KI_HI;
         ST_KI_HI:    state_in = ST_FF_LO;
         ST_FF_LO:    state_in = ST_FF_HI;
         ST_FF_HI:    state_in = ST_FF_ACC;
         ST_FF_ACC:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_DERIV;
            end
         end
         ST_DERIV:    state_in = ST_KD_LO;
         ST_KD_LO:    state_in = ST_KD_HI;
         ST_KD_HI:    state_in = ST_LAST;
         ST_LAST:     state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath commands. Each multiply is registered and consumed in the next state.
   always_comb begin
      req_ready      = 1'b0;
      cmd.capture    = 1'b0;
      cmd.start      = 1'b0;
      cmd.prep       = 1'b0;
      cmd.mul_sel    = MUL_NONE;
      cmd.acc_op     = ACC_NONE;
      cmd.deriv_load = 1'b0;
      cmd.out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            cmd.start   = req_valid && (req_operation == OP_START);
         end
         ST_INC_MUL: begin
            cmd.prep    = 1'b1;
            cmd.mul_sel = MUL_E_DT;
         end
         ST_INC: begin
            cmd.mul_sel = MUL_REF_SQ;
            cmd.acc_op  = ACC_INC;
         end
         ST_SQ: begin
            cmd.mul_sel = MUL_KP_E;
            cmd.acc_op  = ACC_SQ;
         end
         ST_KI_LO: begin
            cmd.mul_sel = MUL_KI_ILO;
            cmd.acc_op  = ACC_FIRST;
         end
         ST_KI_HI: begin
            cmd.mul_sel = MUL_KI_IHI;
            cmd.acc_op  = ACC_ADD_LO;
         end
         ST_FF_LO: begin
            cmd.mul_sel = MUL_FF_QLO;
            cmd.acc_op  = ACC_ADD_HI;
         end
         ST_FF_HI: begin
            cmd.mul_sel = MUL_FF_QHI;
            cmd.acc_op  = ACC_ADD_LO;
         end
         ST_FF_ACC: begin
            cmd.acc_op  = ACC_ADD_HI;
         end
         ST_DIV_WAIT: ;
         ST_DERIV: begin
            cmd.deriv_load = 1'b1;
         end
         ST_KD_LO: begin
            cmd.mul_sel = MUL_KD_DLO;
         end
         ST_KD_HI: begin
            cmd.mul_sel = MUL_KD_DHI;
            cmd.acc_op  = ACC_ADD_LO;
         end
         ST_LAST: begin
            cmd.acc_op  = ACC_ADD_HI;
         end
         ST_OUT: begin
            cmd.out_load = !rsp_valid_ff || rsp_ready;
         end
         default: ;
      endcase
   end

   // Response valid: set when a word is loaded, cleared when it is taken.
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* design/pid_velocity_controller_ff_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Vertical-velocity PID controller with quadratic feedforward on signed
// Q16.16 values. A start word (operation 1) clears the integral, seeds the
// previous error with reference minus measurement and gives no response. A
// control-step word raises its response word with the saturated force
// command and a clipped flag. The derivative term comes from a bit-serial
// divider, one quotient bit per cycle over 49 bits, with the proportional,
// integral and feedforward products run on one shared 33 x 33 multiplier
// while the divider works and the derivative product after it. One word is
// in work at a time; the next word is accepted while a finished response
// still waits to be taken, and a step that finishes before that response is
// taken holds until it is. The user is to write gains and the settle window
// through the csr_ port only while the block is idle; the block itself does
// not enforce this.
module pid_velocity_controller_ff_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   pvc_req_if.sink                             req_ch,
   pvc_rsp_if.source                           rsp_ch,
   input  wire logic                           csr_write_enable,
   input  wire logic [pvc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pvc_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import pvc_pkg::*;

   cmd_type    ctl_cmd;
   status_type dp_status;

   pvc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_operation (req_ch.operation),
      .req_ready     (req_ch.ready),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .cmd           (ctl_cmd),
      .status        (dp_status)
   );

   pvc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (ctl_cmd),
      .status           (dp_status),
      .velocity_meas    (req_ch.velocity_meas),
      .velocity_ref     (req_ch.velocity_ref),
      .ref_stamp        (req_ch.ref_stamp),
      .now_stamp        (req_ch.now_stamp),
      .step_time        (req_ch.step_time),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .drive_force      (rsp_ch.drive_force),
      .clipped          (rsp_ch.clipped)
   );

`ifndef SYNTHESIS
   // A start word never produces a response.
   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.operation == OP_START && !rsp_ch.valid)
      |=> !rsp_ch.valid)
      else $error("response raised after a start word");

   // The output register is only loaded when it is free or being emptied.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.out_load |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("pending response overwritten");

   // The derivative is taken only after the divider has finished.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.deriv_load |-> !dp_status.div_busy)
      else $error("derivative taken from a running divider");

   // A clipped response carries one of the two limits.
   a_clip_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.clipped) |->
      (rsp_ch.drive_force == 32'sh7FFF_FFFF || rsp_ch.drive_force == 32'sh8000_0000))
      else $error("clipped response not at a limit");
`endif

endmodule

`default_nettype wire

/* tb/tb_pid_velocity_controller_ff_core.sv */
`timescale 1ns / 1ps

module tb_pid_velocity_controller_ff_core;
   import pvc_pkg::*;

   localparam int TAIL_CYCLES = 80;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_PER_PHASE = 235;
   localparam longint INTEG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint INTEG_MIN = -64'sh0000_8000_0000_0000;
   localparam logic signed [127:0] FORCE_SUM_MAX = (128'sd1 <<< 47) - 128'sd1;
   localparam logic signed [127:0] FORCE_SUM_MIN = -(128'sd1 <<< 47);

   typedef struct {
      logic                     operation;
      logic signed [DATA_W-1:0] velocity_meas;
      logic signed [DATA_W-1:0] velocity_ref;
      logic [STAMP_W-1:0]       ref_stamp;
      logic [STAMP_W-1:0]       now_stamp;
      logic [DT_W-1:0]          step_time;
      bit                       drain;
   } ctrl_word_t;

   typedef struct {
      logic signed [DATA_W-1:0] drive_force;
      logic                     clipped;
   } force_word_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   pvc_req_if req_if ();
   pvc_rsp_if rsp_if ();

   pid_velocity_controller_ff_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if),
      .rsp_ch           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Register copies and controller state that the force predictor keeps.
   logic signed [DATA_W-1:0] gain_p = '0;
   logic signed [DATA_W-1:0] gain_i = '0;
   logic signed [DATA_W-1:0] gain_d = '0;
   logic signed [DATA_W-1:0] gain_ff = FEEDFWD_GAIN_RST;
   logic [WIN_W-1:0]         settle_win = SETTLE_WINDOW_RST;
   longint                   integ_state = 0;
   longint                   last_error = 0;

   ctrl_word_t  pending_words[$];
   force_word_t expected_force[$];
   ctrl_word_t  sent_word;
   force_word_t predicted;
   force_word_t wanted;
   bit          word_busy;
   bit          feed_open;
   bit          send_burst;
   bit          take_burst;
   int          send_wait;
   int          take_wait;
   int          mismatch_count = 0;
   int          stall_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Works out the force word for one control word and advances the state.
   // A start word clears the integral, seeds the error history and returns 0.
   function automatic bit predict_force(input ctrl_word_t w, output force_word_t f);
      longint err, dt, gap, slope, rv, sq_q;
      logic signed [127:0] opa, opb, total;
      f.drive_force = '0;
      f.clipped = 1'b0;
      err = longint'(w.velocity_ref) - longint'(w.velocity_meas);
      dt = longint'(w.step_time);
      if (w.operation == OP_START) begin
         integ_state = 0;
         last_error = err;
         return 1'b0;
      end
      // Integral accumulates floor(e * dt) in Q32.16 and saturates at 48 bits.
      integ_state = integ_state + ((err * dt) >>> 16);
      if (integ_state > INTEG_MAX) integ_state = INTEG_MAX;
      if (integ_state < INTEG_MIN) integ_state = INTEG_MIN;
      // The settle window compares the plain stamp distance, with no wrap.
      gap = longint'(w.now_stamp) - longint'(w.ref_stamp);
      if (gap < 0) gap = -gap;
      if (gap <= longint'(settle_win)) integ_state = 0;
      // Derivative divides with truncation toward zero.
      slope = 0;
      if (dt != 0) slope = ((err - last_error) * 65536) / dt;
      last_error = err;
      rv = longint'(w.velocity_ref);
      sq_q = (rv * ((rv < 0) ? -rv : rv)) >>> 16;
      // Exact Q96.32 sum of the four terms, then scale and saturate.
      opa = gain_p;
      opb = err;
      total = opa * opb;
      opa = gain_i;
      opb = integ_state;
      total = total + opa * opb;
      opa = gain_d;
      opb = slope;
      total = total + opa * opb;
      opa = gain_ff;
      opb = sq_q;
      total = total + opa * opb;
      if (total > FORCE_SUM_MAX) begin
         f.drive_force = 32'sh7FFF_FFFF;
         f.clipped = 1'b1;
      end else if (total < FORCE_SUM_MIN) begin
         f.drive_force = 32'sh8000_0000;
         f.clipped = 1'b1;
      end else begin
         f.drive_force = total[47:16];
      end
      return 1'b1;
   endfunction

   // A force word is owed, or is being taken at this very edge.
   function automatic bit results_outstanding();
      return expected_force.size() != 0 || (rsp_if.valid && rsp_if.ready);
   endfunction

   function automatic logic [31:0] rand_signed(input int top_bits);
      int mag;
      mag = $urandom_range(0, 1 << $urandom_range(0, top_bits));
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   function automatic logic [31:0] rand_vel();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0000_0001;
            endcase
         end
         default: return rand_signed(28);
      endcase
   endfunction

   function automatic logic [DT_W-1:0] rand_dt();
      logic [DT_W-1:0] v;
      case ($urandom_range(0, 5))
         0: v = DT_W'($urandom);
         1: v = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd1;
         default: v = DT_W'($urandom_range(1, 1 << $urandom_range(4, 18)));
      endcase
      if (v == '0) v = 31'd1;
      return v;
   endfunction

   function automatic logic [31:0] near_stamp(input logic [31:0] t_now);
      if ($urandom_range(0, 5) == 0) return t_now + $urandom_range(0, 300);
      return t_now - $urandom_range(0, 300);
   endfunction

   task automatic log_fault(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic queue_word(input logic op, input logic [31:0] meas, input logic [31:0] vref,
                             input logic [31:0] rs, input logic [31:0] ns,
                             input logic [DT_W-1:0] dt, input bit drain);
      ctrl_word_t w;
      w.operation = op;
      w.velocity_meas = meas;
      w.velocity_ref = vref;
      w.ref_stamp = rs;
      w.now_stamp = ns;
      w.step_time = dt;
      w.drain = drain;
      pending_words.push_back(w);
   endtask

   // Writes one register and mirrors it into the predictor's copy.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_PROP_GAIN:     gain_p = val;
         CSR_INTEG_GAIN:    gain_i = val;
         CSR_DERIV_GAIN:    gain_d = val;
         CSR_FEEDFWD_GAIN:  gain_ff = val;
         CSR_SETTLE_WINDOW: settle_win = val[WIN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_gains(input logic [31:0] kp, input logic [31:0] ki, input logic [31:0] kd,
                             input logic [31:0] ff, input logic [WIN_W-1:0] win);
      feed_open <= 1'b0;
      write_reg(CSR_PROP_GAIN, kp);
      write_reg(CSR_INTEG_GAIN, ki);
      write_reg(CSR_DERIV_GAIN, kd);
      write_reg(CSR_FEEDFWD_GAIN, ff);
      write_reg(CSR_SETTLE_WINDOW, {16'd0, win});
   endtask

   // Waits until every word is taken and every force word is back, then lets
   // the block finish any start word still in work.
   task automatic wait_idle();
      while (pending_words.size() != 0 || word_busy || (req_if.valid && req_if.ready) ||
             results_outstanding())
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Mostly start-then-step runs with a tracking measurement and advancing
   // stamps, mixed with words of any content and runs that lack their start.
   task automatic queue_random(input int count);
      int made, run_len, k;
      logic [31:0] vref, meas, t_now, t_ref;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 4) == 0) begin
            queue_word($urandom_range(0, 1) ? OP_START : OP_STEP, rand_vel(), rand_vel(),
                       $urandom, $urandom, rand_dt(), $urandom_range(0, 149) == 0);
            made++;
         end else begin
            vref = rand_vel();
            meas = vref - rand_signed(20);
            t_now = $urandom;
            t_ref = near_stamp(t_now);
            if ($urandom_range(0, 7) != 0) begin
               queue_word(OP_START, meas, vref, t_ref, t_now, rand_dt(), 1'b0);
               made++;
            end
            run_len = $urandom_range(2, 12);
            for (k = 0; k < run_len; k++) begin
               t_now = t_now + $urandom_range(1, 120);
               if ($urandom_range(0, 4) == 0) begin
                  vref = rand_vel();
                  t_ref = near_stamp(t_now);
               end
               meas = vref - rand_signed(20);
               queue_word(OP_STEP, meas, vref, t_ref, t_now, rand_dt(),
                          $urandom_range(0, 149) == 0);
               made++;
            end
         end
      end
   endtask

   // Driver: offers queued control words, with a drawn gap after each one.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         word_busy = 1'b0;
         send_wait = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            word_busy = 1'b0;
            if (predict_force(sent_word, predicted)) expected_force.push_back(predicted);
         end
         if (!word_busy) begin
            if (send_wait > 0) begin
               send_wait--;
               req_if.valid <= 1'b0;
            end else if (feed_open && pending_words.size() != 0 &&
                         !(pending_words[0].drain && results_outstanding())) begin
               sent_word = pending_words.pop_front();
               req_if.operation <= sent_word.operation;
               req_if.velocity_meas <= sent_word.velocity_meas;
               req_if.velocity_ref <= sent_word.velocity_ref;
               req_if.ref_stamp <= sent_word.ref_stamp;
               req_if.now_stamp <= sent_word.now_stamp;
               req_if.step_time <= sent_word.step_time;
               req_if.valid <= 1'b1;
               word_busy = 1'b1;
               if ($urandom_range(0, 40) == 0) send_burst = !send_burst;
               send_wait = send_burst ? 0 : $urandom_range(0, 3);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: takes force words with drawn stalls and checks them in order.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         take_wait = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_force.size() == 0) begin
               log_fault($sformatf("unexpected force word %0d clipped %0b",
                                   rsp_if.drive_force, rsp_if.clipped));
            end else begin
               wanted = expected_force.pop_front();
               if (wanted.drive_force !== rsp_if.drive_force ||
                   wanted.clipped !== rsp_if.clipped)
                  log_fault($sformatf("force exp %0d got %0d, clipped exp %0b got %0b",
                                      wanted.drive_force, rsp_if.drive_force,
                                      wanted.clipped, rsp_if.clipped));
            end
            if ($urandom_range(0, 40) == 0) take_burst = !take_burst;
            take_wait = take_burst ? 0 : $urandom_range(0, 3);
         end
         if (take_wait > 0) begin
            take_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no word moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.operation = OP_STEP;
      req_if.velocity_meas = '0;
      req_if.velocity_ref = '0;
      req_if.ref_stamp = '0;
      req_if.now_stamp = '0;
      req_if.step_time = '0;
      rsp_if.ready = 1'b0;
      feed_open = 1'b0;
      send_burst = 1'b0;
      take_burst = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Feedforward alone under the reset values, up to both clip limits.
      queue_word(OP_START, 32'h0, 32'h0, 32'h0, 32'h0, 31'h1_0000, 1'b0);
      queue_word(OP_STEP, 32'h0, 32'h0, 32'h0, 32'd100000, 31'h1_0000, 1'b0);
      queue_word(OP_STEP, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'd100000, 31'd1, 1'b0);
      queue_word(OP_STEP, 32'h0, 32'h8000_0000, 32'h0, 32'd100000, 31'd1, 1'b0);
      queue_word(OP_STEP, 32'h0, 32'h1_0000, 32'h0, 32'd100000, 31'h1_0000, 1'b0);
      feed_open <= 1'b1;
      wait_idle();

      // Unity-scale gains: window edges, integral saturation, extreme slopes.
      load_gains(32'h1_0000, 32'h8000, 32'h4000, 32'h100, 16'd150);
      queue_word(OP_START, 32'h0, 32'h2_0000, 32'h0, 32'd1000, 31'h1_0000, 1'b0);
      queue_word(OP_STEP, 32'h8000, 32'h2_0000, 32'h0, 32'd1000, 31'h1_0000, 1'b0);
      queue_word(OP_STEP, 32'h8000, 32'h2_0000, 32'd1150, 32'd1000, 31'h1_0000, 1'b0);
      queue_word(OP_STEP, 32'h8000, 32'h2_0000, 32'd1000, 32'd1151, 31'h1_0000, 1'b0);
      queue_word(OP_STEP, 32'h8000, 32'h2_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h1_0000, 1'b0);
      queue_word(OP_STEP, 32'h8000, 32'h2_0000, 32'hFFFF_FFFF, 32'h0, 31'h1_0000, 1'b0);
      repeat (3)
         queue_word(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'd100000, 31'h7FFF_FFFF,
                    1'b0);
      repeat (2)
         queue_word(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'd100000, 31'h7FFF_FFFF,
                    1'b0);
      queue_word(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'd100000, 31'd1, 1'b0);
      queue_word(OP_START, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 31'd1, 1'b0);
      queue_word(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'd100000, 31'd1, 1'b0);
      queue_word(OP_STEP, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'd100000, 31'h1_0000, 1'b0);
      queue_word(OP_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'd100000, 31'h7FFF_FFFF,
                 1'b0);
      queue_word(OP_START, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 31'd1, 1'b0);
      queue_word(OP_START, 32'h0, 32'h1_0000, 32'h0, 32'h0, 31'd1, 1'b0);
      queue_word(OP_STEP, 32'h0, 32'h1_0000, 32'h0, 32'd100000, 31'h1_0000, 1'b1);
      feed_open <= 1'b1;
      wait_idle();

      // Random phases, each under its own register setting.
      load_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
      queue_random(RANDOM_PER_PHASE);
      feed_open <= 1'b1;
      wait_idle();

      load_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd0);
      queue_random(RANDOM_PER_PHASE);
      feed_open <= 1'b1;
      wait_idle();

      load_gains(32'h1_0000, 32'h0, 32'h0, 32'h0, 16'd0);
      queue_random(RANDOM_PER_PHASE);
      feed_open <= 1'b1;
      wait_idle();

      repeat (3) begin
         load_gains(rand_signed(18), rand_signed(18), rand_signed(12), rand_signed(10),
                    WIN_W'($urandom_range(0, 1000)));
         queue_random(RANDOM_PER_PHASE);
         feed_open <= 1'b1;
         wait_idle();
      end

      load_gains($urandom, $urandom, $urandom, $urandom, WIN_W'($urandom_range(0, 65535)));
      queue_random(RANDOM_PER_PHASE);
      feed_open <= 1'b1;
      wait_idle();

      load_gains(32'h0, 32'h0, 32'h0, FEEDFWD_GAIN_RST, SETTLE_WINDOW_RST);
      queue_random(RANDOM_PER_PHASE);
      feed_open <= 1'b1;
      wait_idle();

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
